>>> design/assert_macros.svh
// Assertion macros included by the classifier.
// Each macro samples on the rising edge of i_clk and is disabled while i_rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`endif
`endif

>>> design/rzlc_pkg.sv
package rzlc_pkg;

    // Widths of the channel fields.
    localparam int SAMPLE_W = 24;
    localparam int LEVEL_W  = 3;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int LEN_CFG_W  = 11;
    localparam int THR_W      = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH = 3'd0,
        CFG_STD_DIVISOR   = 3'd1,
        CFG_THR_XHIGH     = 3'd2,
        CFG_THR_HIGH      = 3'd3,
        CFG_THR_MEDIUM    = 3'd4,
        CFG_THR_NORMAL    = 3'd5
    } t_cfg_idx;

    // Shared multiplier: operand A in three chunks, operand B in two chunks.
    localparam int CHUNK_W   = 32;
    localparam int MUL_A_W   = 96;
    localparam int MUL_B_W   = 64;
    localparam int PROD_W    = 128;
    localparam int MUL_STEPS = 6;
    localparam int STEP_W    = 3;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] res;
    } t_mul_rsp;

    // Result levels.
    localparam logic [LEVEL_W-1:0] LEVEL_LOW   = 3'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_XHIGH = 3'd4;

endpackage

>>> design/rzlc_if.sv
// Input channel: one volume sample per transfer.
interface rzlc_in_if;
    logic                          valid;
    logic                          ready;
    logic [rzlc_pkg::SAMPLE_W-1:0] sample;
    logic                          start_series;

    modport source(output valid, output sample, output start_series, input ready);
    modport sink(input valid, input sample, input start_series, output ready);
endinterface

// Output channel: one level per transfer.
interface rzlc_out_if;
    logic                         valid;
    logic                         ready;
    logic [rzlc_pkg::LEVEL_W-1:0] level;
    logic                         ready_res;

    modport source(output valid, output level, output ready_res, input ready);
    modport sink(input valid, input level, input ready_res, output ready);
endinterface

>>> design/rzlc_mul.sv
// Multi-word multiplier: one 32x32 partial product per cycle, accumulated into a
// 128-bit result in the accumulate stage. A request walks every chunk pair of A and B.
module rzlc_mul (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rzlc_pkg::t_mul_req i_req,
    output rzlc_pkg::t_mul_rsp o_rsp
);

    logic [rzlc_pkg::MUL_A_W-1:0]   r_a;
    logic [rzlc_pkg::MUL_B_W-1:0]   r_b;
    logic [rzlc_pkg::STEP_W-1:0]    r_step;
    logic                           r_busy;
    logic [2*rzlc_pkg::CHUNK_W-1:0] r_p;
    logic [1:0]                     r_sh;
    logic                           r_pv;
    logic                           r_plast;
    logic [rzlc_pkg::PROD_W-1:0]    r_acc;
    logic                           r_done;

    logic [1:0]                     a_sel;
    logic                           b_sel;
    logic [rzlc_pkg::CHUNK_W-1:0]   a_chunk;
    logic [rzlc_pkg::CHUNK_W-1:0]   b_chunk;
    logic                           last_step;

    // Chunk selection for the current step: A chunk is step/2, B chunk is step%2.
    always_comb begin
        a_sel     = r_step[2:1];
        b_sel     = r_step[0];
        case (a_sel)
            2'd0:    a_chunk = r_a[rzlc_pkg::CHUNK_W-1:0];
            2'd1:    a_chunk = r_a[2*rzlc_pkg::CHUNK_W-1:rzlc_pkg::CHUNK_W];
            default: a_chunk = r_a[3*rzlc_pkg::CHUNK_W-1:2*rzlc_pkg::CHUNK_W];
        endcase
        b_chunk   = b_sel ? r_b[2*rzlc_pkg::CHUNK_W-1:rzlc_pkg::CHUNK_W]
                          : r_b[rzlc_pkg::CHUNK_W-1:0];
        last_step = (r_step == rzlc_pkg::STEP_W'(rzlc_pkg::MUL_STEPS - 1));
    end

    // Partial product stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pv   <= 1'b0;
        end else if (i_req.start) begin
            r_a    <= i_req.a;
            r_b    <= i_req.b;
            r_step <= '0;
            r_busy <= 1'b1;
            r_pv   <= 1'b0;
        end else if (r_busy) begin
            r_p     <= a_chunk * b_chunk;
            r_sh    <= a_sel + 2'(b_sel);
            r_pv    <= 1'b1;
            r_plast <= last_step;
            r_step  <= r_step + 1'b1;
            if (last_step) begin
                r_busy <= 1'b0;
            end
        end else begin
            r_pv <= 1'b0;
        end
    end

    // Accumulate stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_acc <= '0;
            end else if (r_pv) begin
                r_acc  <= r_acc + (rzlc_pkg::PROD_W'(r_p) << (rzlc_pkg::CHUNK_W * r_sh));
                r_done <= r_plast;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.res  = r_acc;

endmodule

>>> design/rolling_zscore_level_classifier.sv
// Rolling z-score level classifier.
// Input channel i_in carries one unsigned sample and a start_series flag per transfer;
// start_series empties the window before the sample is taken. Output channel o_out
// carries one level (0 low to 4 extra high) and ready_res per input transfer.
// Until the window holds window_length samples the result is level 0 with ready_res low.
// Configuration is written through i_cfg_we, i_cfg_idx and i_cfg_data; the user must
// write it only while the block is idle, as the block does not enforce this. A write
// to window_length empties the window. Each item is worked by one shared 32x32
// multiplier under a sequencer. While the window fills an item needs a single product;
// once it is full more follow, their number set by how many of the four thresholds
// need a full product compare. i_in.ready is high only while idle.
// The result is held in an output register until it is transferred; while the
// receiver stalls no new sample is taken. Reset empties the window and restores the
// register defaults; the sample memory needs no clearing pass.
module rolling_zscore_level_classifier #(
    parameter int MAX_WINDOW  = 1024,
    parameter int SAMPLE_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    rzlc_in_if.sink                           i_in,
    rzlc_out_if.source                        o_out,
    input  logic                              i_cfg_we,
    input  logic [rzlc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [rzlc_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int AW     = $clog2(MAX_WINDOW);
    localparam int LEN_W  = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W  = SAMPLE_BITS + LEN_W;
    localparam int SQ_W   = 2 * SAMPLE_BITS + LEN_W;
    localparam int LQ_W   = 2 * SAMPLE_BITS + 2 * LEN_W;
    localparam int LHS_W  = LQ_W + rzlc_pkg::LEN_CFG_W + 16;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_RD   = 14'b00000000000010,
        S_WX   = 14'b00000000000100,
        S_WO   = 14'b00000000001000,
        S_WLX  = 14'b00000000010000,
        S_WLQ  = 14'b00000000100000,
        S_WSS  = 14'b00000001000000,
        S_WAA  = 14'b00000010000000,
        S_WLHS = 14'b00000100000000,
        S_TH   = 14'b00001000000000,
        S_WT2  = 14'b00010000000000,
        S_WTK  = 14'b00100000000000,
        S_WRHS = 14'b01000000000000,
        S_OUT  = 14'b10000000000000
    } t_state;

    t_state                             r_state;
    logic [LEN_W-1:0]                   r_len;
    logic [rzlc_pkg::LEN_CFG_W-1:0]     r_div;
    logic [rzlc_pkg::THR_W-1:0]         r_thr [4];
    logic [SAMPLE_BITS-1:0]             mem [MAX_WINDOW];
    logic [SAMPLE_BITS-1:0]             r_rdata;
    logic [SAMPLE_BITS-1:0]             r_x;
    logic [SUM_W-1:0]                   r_sum;
    logic [SQ_W-1:0]                    r_sq;
    logic [LEN_W-1:0]                   r_fill;
    logic [AW-1:0]                      r_wp;
    logic                               r_full_before;
    logic                               r_aneg;
    logic [SUM_W-1:0]                   r_amag;
    logic [LQ_W-1:0]                    r_lq;
    logic [LQ_W-1:0]                    r_m;
    logic [LHS_W-1:0]                   r_lhs;
    logic [1:0]                         r_ti;
    logic [rzlc_pkg::LEVEL_W-1:0]       r_level;
    logic                               r_rr;
    rzlc_pkg::t_mul_req                 r_mreq;
    rzlc_pkg::t_mul_rsp                 mrsp;

    logic                               in_xfer;
    logic                               out_xfer;
    logic [AW-1:0]                      wp_fix;
    logic [LEN_W-1:0]                   wp_inc;
    logic                               full_now;
    logic [SUM_W-1:0]                   lx;
    logic [rzlc_pkg::THR_W-1:0]         thr_cur;
    logic                               tneg;
    logic [rzlc_pkg::THR_W-1:0]         tmag;
    logic                               above;
    logic [rzlc_pkg::LEVEL_W-1:0]       th_level;

    // Effective window length: zero counts as one, large values saturate.
    function automatic logic [LEN_W-1:0] f_len(input logic [rzlc_pkg::LEN_CFG_W-1:0] v);
        logic [13:0] w;
        w = 14'(v);
        if (w == '0) begin
            return LEN_W'(1);
        end else if (w > 14'(MAX_WINDOW)) begin
            return LEN_W'(MAX_WINDOW);
        end
        return LEN_W'(w);
    endfunction

    rzlc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_mreq),
        .o_rsp   (mrsp)
    );

    // Handshakes and shared decode.
    always_comb begin
        in_xfer  = i_in.valid && (r_state == S_IDLE);
        out_xfer = o_out.ready && (r_state == S_OUT);
        wp_fix   = (LEN_W'(r_wp) >= r_len) ? '0 : r_wp;
        wp_inc   = LEN_W'(wp_fix) + 1'b1;
        full_now = (r_fill >= r_len);
        lx       = SUM_W'(mrsp.res);
        thr_cur  = r_thr[r_ti];
        tneg     = thr_cur[rzlc_pkg::THR_W-1];
        tmag     = tneg ? (~thr_cur + 1'b1) : thr_cur;
        above    = r_aneg ? (rzlc_pkg::PROD_W'(r_lhs) < mrsp.res)
                          : (rzlc_pkg::PROD_W'(r_lhs) > mrsp.res);
        th_level = rzlc_pkg::LEVEL_XHIGH - rzlc_pkg::LEVEL_W'(r_ti);
    end

    // Sample memory: the slot is read before it is overwritten.
    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_rdata      <= mem[wp_fix];
            mem[wp_fix]  <= r_x;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= f_len(11'd610);
            r_div    <= 11'd610;
            r_thr[0] <= 16'd1024;
            r_thr[1] <= 16'd640;
            r_thr[2] <= 16'd256;
            r_thr[3] <= 16'hFF80;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rzlc_pkg::CFG_WINDOW_LENGTH: r_len <= f_len(i_cfg_data[10:0]);
                rzlc_pkg::CFG_STD_DIVISOR: begin
                    r_div <= (i_cfg_data[10:0] == '0) ? 11'd1 : i_cfg_data[10:0];
                end
                rzlc_pkg::CFG_THR_XHIGH:  r_thr[0] <= i_cfg_data;
                rzlc_pkg::CFG_THR_HIGH:   r_thr[1] <= i_cfg_data;
                rzlc_pkg::CFG_THR_MEDIUM: r_thr[2] <= i_cfg_data;
                rzlc_pkg::CFG_THR_NORMAL: r_thr[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer: window update, then the exact threshold compares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_mreq.start <= 1'b0;
            r_sum        <= '0;
            r_sq         <= '0;
            r_fill       <= '0;
            r_wp         <= '0;
        end else begin
            r_mreq.start <= 1'b0;
            if (i_cfg_we && (i_cfg_idx == rzlc_pkg::CFG_WINDOW_LENGTH)) begin
                r_sum  <= '0;
                r_sq   <= '0;
                r_fill <= '0;
                r_wp   <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_x <= i_in.sample[SAMPLE_BITS-1:0];
                        if (i_in.start_series) begin
                            r_sum  <= '0;
                            r_sq   <= '0;
                            r_fill <= '0;
                            r_wp   <= '0;
                        end
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_wp          <= (wp_inc >= r_len) ? '0 : AW'(wp_inc);
                    r_full_before <= full_now;
                    if (!full_now) begin
                        r_fill <= r_fill + 1'b1;
                    end
                    r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_x),
                                 b: rzlc_pkg::MUL_B_W'(r_x)};
                    r_state <= S_WX;
                end
                S_WX, S_WO: begin
                    if (mrsp.done) begin
                        if (r_state == S_WX) begin
                            r_sum <= r_sum + SUM_W'(r_x);
                            r_sq  <= r_sq + SQ_W'(mrsp.res);
                        end else begin
                            r_sum <= r_sum - SUM_W'(r_rdata);
                            r_sq  <= r_sq - SQ_W'(mrsp.res);
                        end
                        if ((r_state == S_WX) && r_full_before) begin
                            r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_rdata),
                                         b: rzlc_pkg::MUL_B_W'(r_rdata)};
                            r_state <= S_WO;
                        end else if (!full_now) begin
                            r_level <= rzlc_pkg::LEVEL_LOW;
                            r_rr    <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_len),
                                         b: rzlc_pkg::MUL_B_W'(r_x)};
                            r_state <= S_WLX;
                        end
                    end
                end
                S_WLX: begin
                    if (mrsp.done) begin
                        r_aneg  <= (lx < r_sum);
                        r_amag  <= (lx < r_sum) ? (r_sum - lx) : (lx - r_sum);
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_sq),
                                     b: rzlc_pkg::MUL_B_W'(r_len)};
                        r_state <= S_WLQ;
                    end
                end
                S_WLQ: begin
                    if (mrsp.done) begin
                        r_lq    <= LQ_W'(mrsp.res);
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_sum),
                                     b: rzlc_pkg::MUL_B_W'(r_sum)};
                        r_state <= S_WSS;
                    end
                end
                S_WSS: begin
                    if (mrsp.done) begin
                        if (r_lq > LQ_W'(mrsp.res)) begin
                            r_m     <= r_lq - LQ_W'(mrsp.res);
                            r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_amag),
                                         b: rzlc_pkg::MUL_B_W'(r_amag)};
                            r_state <= S_WAA;
                        end else begin
                            // Zero deviation: any rise above the mean is extra high.
                            r_level <= (!r_aneg && (r_amag != '0)) ? rzlc_pkg::LEVEL_XHIGH
                                                                  : rzlc_pkg::LEVEL_LOW;
                            r_rr    <= 1'b1;
                            r_state <= S_OUT;
                        end
                    end
                end
                S_WAA: begin
                    if (mrsp.done) begin
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(mrsp.res),
                                     b: rzlc_pkg::MUL_B_W'(r_div)};
                        r_state <= S_WLHS;
                    end
                end
                S_WLHS: begin
                    if (mrsp.done) begin
                        r_lhs   <= LHS_W'(mrsp.res) << 16;
                        r_ti    <= '0;
                        r_state <= S_TH;
                    end
                end
                S_TH: begin
                    // Opposite signs settle the compare without a product.
                    if (!r_aneg && tneg) begin
                        r_level <= th_level;
                        r_rr    <= 1'b1;
                        r_state <= S_OUT;
                    end else if (r_aneg && !tneg) begin
                        if (r_ti == 2'd3) begin
                            r_level <= rzlc_pkg::LEVEL_LOW;
                            r_rr    <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_ti <= r_ti + 1'b1;
                        end
                    end else begin
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(tmag),
                                     b: rzlc_pkg::MUL_B_W'(tmag)};
                        r_state <= S_WT2;
                    end
                end
                S_WT2: begin
                    if (mrsp.done) begin
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(mrsp.res),
                                     b: rzlc_pkg::MUL_B_W'(r_len)};
                        r_state <= S_WTK;
                    end
                end
                S_WTK: begin
                    if (mrsp.done) begin
                        r_mreq  <= '{start: 1'b1, a: rzlc_pkg::MUL_A_W'(r_m),
                                     b: rzlc_pkg::MUL_B_W'(mrsp.res)};
                        r_state <= S_WRHS;
                    end
                end
                S_WRHS: begin
                    if (mrsp.done) begin
                        if (above) begin
                            r_level <= th_level;
                            r_rr    <= 1'b1;
                            r_state <= S_OUT;
                        end else if (r_ti == 2'd3) begin
                            r_level <= rzlc_pkg::LEVEL_LOW;
                            r_rr    <= 1'b1;
                            r_state <= S_OUT;
                        end else begin
                            r_ti    <= r_ti + 1'b1;
                            r_state <= S_TH;
                        end
                    end
                end
                S_OUT: begin
                    if (out_xfer) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Channel outputs.
    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = (r_state == S_OUT);
    assign o_out.level     = r_level;
    assign o_out.ready_res = r_rr;

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_one_side, !(i_in.ready && o_out.valid), "input and output both open")
    `ASSERT_IMPLIES(a_level_range, o_out.valid, o_out.level <= rzlc_pkg::LEVEL_XHIGH, "bad level")
    `ASSERT_IMPLIES(a_not_full_low, o_out.valid && !o_out.ready_res, o_out.level == '0, "level set early")
    `ASSERT_ALWAYS(a_fill_bound, r_fill <= r_len, "fill count beyond window length")

endmodule
